### sv/overlapped_tile_walker_core_assert.svh
// Assertion macros for the overlapped tile walker
`ifndef OVERLAPPED_TILE_WALKER_CORE_ASSERT_SVH
`define OVERLAPPED_TILE_WALKER_CORE_ASSERT_SVH

`ifndef SYNTH
`define OTW_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define OTW_ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define OTW_ASSERT(lbl, clk, rstn, prop, msg)
`define OTW_ASSERT_NEVER(lbl, clk, rstn, expr, msg)
`endif

`endif

### sv/otw_pkg.sv
// Shared types, constants and helper functions of the overlapped tile walker
package otw_pkg;

    localparam int MAX_DIM   = 16384;
    localparam int MAX_TILE  = 4096;
    localparam int MAX_ALIGN = 256;

    localparam int DIM_W   = 15;
    localparam int TILE_W  = 13;
    localparam int OVL_W   = 10;
    localparam int GRACE_W = 12;
    localparam int ALIGN_W = 9;
    localparam int CFG_W   = 13;
    localparam int IDX_W   = 3;
    localparam int LIM_W   = 14;

    typedef enum logic [IDX_W-1:0] {
        CFG_TILE_WIDTH     = 3'd0,
        CFG_TILE_HEIGHT    = 3'd1,
        CFG_TILE_OVERLAP   = 3'd2,
        CFG_EXTEND_GRACE   = 3'd3,
        CFG_SIZE_ALIGNMENT = 3'd4
    } cfg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ROWS_START,
        S_ROWS_WAIT,
        S_COLS_START,
        S_COLS_WAIT,
        S_TILE,
        S_LOAD,
        S_ALPHA_OUT,
        S_COLOUR_OUT
    } state_t;

    typedef struct packed {
        logic load_in;
        logic rem_start;
        logic rem_sel_cols;
        logic store_rows;
        logic store_cols;
        logic compute;
        logic load_alpha;
        logic load_colour;
        logic advance;
    } cmd_t;

    typedef struct packed {
        logic img_active;
        logic alpha;
        logic rem_done;
    } sts_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = DIM_W'(1);
        end
        else if (v > DIM_W'(MAX_DIM))
        begin
            r = DIM_W'(MAX_DIM);
        end
        return r;
    endfunction

    function automatic logic [TILE_W-1:0] clamp_tile(input logic [TILE_W-1:0] v);
        logic [TILE_W-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = TILE_W'(1);
        end
        else if (v > TILE_W'(MAX_TILE))
        begin
            r = TILE_W'(MAX_TILE);
        end
        return r;
    endfunction

    function automatic logic [ALIGN_W-1:0] clamp_align(input logic [ALIGN_W-1:0] v);
        logic [ALIGN_W-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = ALIGN_W'(1);
        end
        else if (v > ALIGN_W'(MAX_ALIGN))
        begin
            r = ALIGN_W'(MAX_ALIGN);
        end
        return r;
    endfunction

    // origin step: size minus overlap, at least 1
    function automatic logic [TILE_W-1:0] tile_advance(input logic [TILE_W-1:0] step,
                                                       input logic [OVL_W-1:0] ovl);
        logic [TILE_W-1:0] r;
        if (TILE_W'(ovl) >= step)
        begin
            r = TILE_W'(1);
        end
        else
        begin
            r = step - TILE_W'(ovl);
        end
        return r;
    endfunction

endpackage

### sv/otw_rem.sv
// Iterative restoring remainder unit, one dividend bit per cycle
`include "overlapped_tile_walker_core_assert.svh"

module otw_rem (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [otw_pkg::DIM_W-1:0]   dividend,
    input  logic [otw_pkg::ALIGN_W-1:0] divisor,
    output logic                        done,
    output logic [otw_pkg::ALIGN_W-1:0] rem
);
    import otw_pkg::*;

    localparam int CNT_W = $clog2(DIM_W);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [DIM_W-1:0]    dvd_reg, dvd_next;
    logic [ALIGN_W-1:0]  rem_reg, rem_next;
    logic [ALIGN_W-1:0]  dsr_reg, dsr_next;
    logic [ALIGN_W:0]    part;
    logic [ALIGN_W:0]    diff;

    assign part = {rem_reg, dvd_reg[DIM_W-1]};
    assign diff = part - {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start && !busy_reg)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[DIM_W-2:0], 1'b0};
            rem_next = (part >= {1'b0, dsr_reg}) ? diff[ALIGN_W-1:0] : part[ALIGN_W-1:0];
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(DIM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

    `OTW_ASSERT(a_rem_below_divisor, clk, rst_n, done_reg |-> (rem_reg < dsr_reg), "remainder not below divisor")
    `OTW_ASSERT_NEVER(a_done_while_busy, clk, rst_n, done_reg && busy_reg, "done raised while still iterating")

endmodule

### sv/otw_dp.sv
// Datapath: settings, image geometry, tile origin walk and result registers
`include "overlapped_tile_walker_core_assert.svh"

module otw_dp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  otw_pkg::cmd_t               cmd,
    output otw_pkg::sts_t               sts,
    input  logic                        cfg_we,
    input  logic [otw_pkg::IDX_W-1:0]   cfg_index,
    input  logic [otw_pkg::CFG_W-1:0]   cfg_data,
    input  logic [otw_pkg::DIM_W-1:0]   image_height,
    input  logic [otw_pkg::DIM_W-1:0]   image_width,
    input  logic                        with_alpha,
    output logic [otw_pkg::DIM_W-1:0]   tile_y,
    output logic [otw_pkg::DIM_W-1:0]   tile_x,
    output logic [otw_pkg::TILE_W-1:0]  tile_rows,
    output logic [otw_pkg::TILE_W-1:0]  tile_cols,
    output logic                        top_edge,
    output logic                        bottom_edge,
    output logic                        left_edge,
    output logic                        right_edge,
    output logic                        alpha_pass,
    output logic                        image_begin,
    output logic                        image_end,
    output logic                        last
);
    import otw_pkg::*;

    logic [TILE_W-1:0]  tile_width_reg, tile_height_reg;
    logic [OVL_W-1:0]   tile_overlap_reg;
    logic [GRACE_W-1:0] extend_grace_reg;
    logic [ALIGN_W-1:0] size_alignment_reg;

    logic [DIM_W-1:0]   img_h_reg, img_w_reg;
    logic               alpha_reg;
    logic               img_active_reg;
    logic [DIM_W-1:0]   aligned_rows_reg, aligned_cols_reg;
    logic [DIM_W-1:0]   row_org_reg, col_org_reg;
    logic [DIM_W-1:0]   t_reg;

    logic [TILE_W-1:0]  th_reg, tw_reg, adv_h_reg, adv_w_reg;
    logic               h_end_reg, w_end_reg, h_beg_reg, w_beg_reg;

    logic [ALIGN_W-1:0] align_c;
    logic [TILE_W-1:0]  step_h, step_w;
    logic [DIM_W-1:0]   t_sel;
    logic [DIM_W-1:0]   remain_h, remain_w;
    logic [LIM_W-1:0]   lim_h, lim_w;
    logic               h_end_c, w_end_c;
    logic               rem_done;
    logic [ALIGN_W-1:0] rem_val;

    assign align_c = clamp_align(size_alignment_reg);
    assign step_h  = clamp_tile(tile_height_reg);
    assign step_w  = clamp_tile(tile_width_reg);

    assign t_sel = (cmd.rem_sel_cols ? clamp_dim(img_w_reg) : clamp_dim(img_h_reg))
                   + DIM_W'(align_c) - DIM_W'(1);

    otw_rem u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.rem_start),
        .dividend (t_sel),
        .divisor  (align_c),
        .done     (rem_done),
        .rem      (rem_val)
    );

    assign remain_h = aligned_rows_reg - row_org_reg;
    assign remain_w = aligned_cols_reg - col_org_reg;
    assign lim_h    = LIM_W'(step_h) + LIM_W'(extend_grace_reg);
    assign lim_w    = LIM_W'(step_w) + LIM_W'(extend_grace_reg);
    assign h_end_c  = remain_h <= DIM_W'(lim_h);
    assign w_end_c  = remain_w <= DIM_W'(lim_w);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tile_width_reg     <= TILE_W'(256);
            tile_height_reg    <= TILE_W'(256);
            tile_overlap_reg   <= OVL_W'(16);
            extend_grace_reg   <= '0;
            size_alignment_reg <= ALIGN_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TILE_WIDTH:     tile_width_reg     <= cfg_data[TILE_W-1:0];
                CFG_TILE_HEIGHT:    tile_height_reg    <= cfg_data[TILE_W-1:0];
                CFG_TILE_OVERLAP:   tile_overlap_reg   <= cfg_data[OVL_W-1:0];
                CFG_EXTEND_GRACE:   extend_grace_reg   <= cfg_data[GRACE_W-1:0];
                CFG_SIZE_ALIGNMENT: size_alignment_reg <= cfg_data[ALIGN_W-1:0];
                default:            ;
            endcase
        end
    end

    // image state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            img_active_reg   <= 1'b0;
            aligned_rows_reg <= '0;
            aligned_cols_reg <= '0;
            row_org_reg      <= '0;
            col_org_reg      <= '0;
        end
        else
        begin
            if (cmd.load_in && !img_active_reg)
            begin
                img_active_reg <= 1'b1;
                row_org_reg    <= '0;
                col_org_reg    <= '0;
            end
            if (cmd.store_rows)
            begin
                aligned_rows_reg <= t_reg - DIM_W'(rem_val);
            end
            if (cmd.store_cols)
            begin
                aligned_cols_reg <= t_reg - DIM_W'(rem_val);
            end
            if (cmd.advance)
            begin
                if (w_end_reg)
                begin
                    col_org_reg <= '0;
                    if (h_end_reg)
                    begin
                        row_org_reg    <= '0;
                        img_active_reg <= 1'b0;
                    end
                    else
                    begin
                        row_org_reg <= row_org_reg + DIM_W'(adv_h_reg);
                    end
                end
                else
                begin
                    col_org_reg <= col_org_reg + DIM_W'(adv_w_reg);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            alpha_reg <= with_alpha;
            if (!img_active_reg)
            begin
                img_h_reg <= image_height;
                img_w_reg <= image_width;
            end
        end
        if (cmd.rem_start)
        begin
            t_reg <= t_sel;
        end
        if (cmd.compute)
        begin
            th_reg    <= h_end_c ? remain_h[TILE_W-1:0] : step_h;
            tw_reg    <= w_end_c ? remain_w[TILE_W-1:0] : step_w;
            h_end_reg <= h_end_c;
            w_end_reg <= w_end_c;
            h_beg_reg <= (row_org_reg == '0);
            w_beg_reg <= (col_org_reg == '0);
            adv_h_reg <= tile_advance(step_h, tile_overlap_reg);
            adv_w_reg <= tile_advance(step_w, tile_overlap_reg);
        end
        if (cmd.load_alpha || cmd.load_colour)
        begin
            tile_y      <= row_org_reg;
            tile_x      <= col_org_reg;
            tile_rows   <= th_reg;
            tile_cols   <= tw_reg;
            top_edge    <= h_beg_reg;
            bottom_edge <= h_end_reg;
            left_edge   <= w_beg_reg;
            right_edge  <= w_end_reg;
            alpha_pass  <= cmd.load_alpha;
            image_begin <= h_beg_reg && w_beg_reg && (cmd.load_alpha || !alpha_reg);
            image_end   <= cmd.load_colour && h_end_reg && w_end_reg;
            last        <= cmd.load_colour;
        end
    end

    assign sts.img_active = img_active_reg;
    assign sts.alpha      = alpha_reg;
    assign sts.rem_done   = rem_done;

    `OTW_ASSERT(a_origin_inside, clk, rst_n,
        cmd.compute |-> (row_org_reg < aligned_rows_reg && col_org_reg < aligned_cols_reg),
        "tile origin outside image")
    `OTW_ASSERT(a_tile_nonzero, clk, rst_n,
        cmd.compute |=> (th_reg != '0 && tw_reg != '0),
        "empty tile computed")

endmodule

### sv/otw_ctrl.sv
// Controller: sequences image alignment, tile computation and result requests
`include "overlapped_tile_walker_core_assert.svh"

module otw_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    output logic          out_valid,
    input  logic          out_stall,
    input  otw_pkg::sts_t sts,
    output otw_pkg::cmd_t cmd
);
    import otw_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        out_valid  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = sts.img_active ? S_TILE : S_ROWS_START;
                end
            end
            S_ROWS_START:
            begin
                cmd.rem_start = 1'b1;
                state_next    = S_ROWS_WAIT;
            end
            S_ROWS_WAIT:
            begin
                if (sts.rem_done)
                begin
                    cmd.store_rows = 1'b1;
                    state_next     = S_COLS_START;
                end
            end
            S_COLS_START:
            begin
                cmd.rem_start    = 1'b1;
                cmd.rem_sel_cols = 1'b1;
                state_next       = S_COLS_WAIT;
            end
            S_COLS_WAIT:
            begin
                if (sts.rem_done)
                begin
                    cmd.store_cols = 1'b1;
                    state_next     = S_TILE;
                end
            end
            S_TILE:
            begin
                cmd.compute = 1'b1;
                state_next  = S_LOAD;
            end
            S_LOAD:
            begin
                if (sts.alpha)
                begin
                    cmd.load_alpha = 1'b1;
                    state_next     = S_ALPHA_OUT;
                end
                else
                begin
                    cmd.load_colour = 1'b1;
                    state_next      = S_COLOUR_OUT;
                end
            end
            S_ALPHA_OUT:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    cmd.load_colour = 1'b1;
                    state_next      = S_COLOUR_OUT;
                end
            end
            S_COLOUR_OUT:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    cmd.advance = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `OTW_ASSERT_NEVER(a_no_take_while_pending, clk, rst_n,
        out_valid && !in_stall,
        "request taken while result pending")
    `OTW_ASSERT(a_new_image_aligns, clk, rst_n,
        (in_valid && !in_stall && !sts.img_active) |=> (state_reg == S_ROWS_START),
        "new image skipped alignment")
    `OTW_ASSERT(a_alpha_then_colour, clk, rst_n,
        (state_reg == S_ALPHA_OUT && !out_stall) |=> (state_reg == S_COLOUR_OUT && out_valid),
        "alpha pass not followed by colour pass")

endmodule

### sv/overlapped_tile_walker_core.sv
// Top level of the overlapped tile walker
//
//  channel   direction  handshake             payload
//  in        input      in_valid / in_stall   image_height, image_width, with_alpha
//  out       output     out_valid / out_stall tile origin, size, edge and pass flags
//  cfg       input      cfg_we                cfg_index, cfg_data
//
//  One request at a time. Within an image a request steps through tile computation
//  (S_TILE) and result load (S_LOAD) before the first result is offered; after an
//  alpha pass is taken the colour pass is offered next, and output stall holds either.
//  Image start runs the iterative remainder unit for rows, then columns (alignment).
//  Reset (rst_n low, asynchronous) clears the walk state and loads register defaults.
//  in_stall is high from acceptance until the colour pass result is taken.

module overlapped_tile_walker_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [otw_pkg::IDX_W-1:0]   cfg_index,
    input  logic [otw_pkg::CFG_W-1:0]   cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [otw_pkg::DIM_W-1:0]   image_height,
    input  logic [otw_pkg::DIM_W-1:0]   image_width,
    input  logic                        with_alpha,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [otw_pkg::DIM_W-1:0]   tile_y,
    output logic [otw_pkg::DIM_W-1:0]   tile_x,
    output logic [otw_pkg::TILE_W-1:0]  tile_rows,
    output logic [otw_pkg::TILE_W-1:0]  tile_cols,
    output logic                        top_edge,
    output logic                        bottom_edge,
    output logic                        left_edge,
    output logic                        right_edge,
    output logic                        alpha_pass,
    output logic                        image_begin,
    output logic                        image_end,
    output logic                        last
);
    import otw_pkg::*;

    cmd_t cmd;
    sts_t sts;

    otw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    otw_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .image_height (image_height),
        .image_width  (image_width),
        .with_alpha   (with_alpha),
        .tile_y       (tile_y),
        .tile_x       (tile_x),
        .tile_rows    (tile_rows),
        .tile_cols    (tile_cols),
        .top_edge     (top_edge),
        .bottom_edge  (bottom_edge),
        .left_edge    (left_edge),
        .right_edge   (right_edge),
        .alpha_pass   (alpha_pass),
        .image_begin  (image_begin),
        .image_end    (image_end),
        .last         (last)
    );

endmodule

### tb/tb_overlapped_tile_walker_core.sv
`timescale 1ns / 100ps
// Testbench for overlapped_tile_walker_core: directed and random image walks checked tile by tile
module tb_overlapped_tile_walker_core;
    import otw_pkg::*;

    localparam logic [IDX_W-1:0] CFG_SPARE_FIRST = 3'd5;
    localparam logic [IDX_W-1:0] CFG_SPARE_LAST  = 3'd7;
    localparam int SETTLE_CYCLES       = 12;
    localparam int HOLD_CYCLES         = 300;
    localparam int SETTING_ITEMS       = 60;
    localparam int PHASE_ITEMS         = 500;
    localparam int MAX_TILES_PER_IMAGE = 64;
    localparam int DIM_FIELD_MAX       = 32767;
    localparam int CFG_FIELD_MAX       = 8191;

    typedef struct packed {
        logic [DIM_W-1:0]  y;
        logic [DIM_W-1:0]  x;
        logic [TILE_W-1:0] rows;
        logic [TILE_W-1:0] cols;
        logic              top;
        logic              bottom;
        logic              left;
        logic              right;
        logic              alpha;
        logic              img_begin;
        logic              img_end;
        logic              is_last;
    } tile_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_we;
    logic [IDX_W-1:0]    cfg_index;
    logic [CFG_W-1:0]    cfg_data;
    logic                in_valid;
    logic                in_stall;
    logic [DIM_W-1:0]    image_height;
    logic [DIM_W-1:0]    image_width;
    logic                with_alpha;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [DIM_W-1:0]    tile_y;
    logic [DIM_W-1:0]    tile_x;
    logic [TILE_W-1:0]   tile_rows;
    logic [TILE_W-1:0]   tile_cols;
    logic                top_edge;
    logic                bottom_edge;
    logic                left_edge;
    logic                right_edge;
    logic                alpha_pass;
    logic                image_begin;
    logic                image_end;
    logic                last;

    // register copies, reset values
    logic [TILE_W-1:0]  reg_tile_w  = 13'd256;
    logic [TILE_W-1:0]  reg_tile_h  = 13'd256;
    logic [OVL_W-1:0]   reg_overlap = 10'd16;
    logic [GRACE_W-1:0] reg_grace   = 12'd0;
    logic [ALIGN_W-1:0] reg_align   = 9'd1;

    int unsigned walk_row   = 0;
    int unsigned walk_col   = 0;
    int unsigned span_rows  = 0;
    int unsigned span_cols  = 0;
    bit          image_open = 1'b0;

    tile_t tiles_due[$];
    int    err_count     = 0;
    int    send_idle_pct = 0;
    int    recv_idle_pct = 0;
    bit    hold_on       = 1'b0;
    event  hold_start;

    overlapped_tile_walker_core DUT (.*);

    always #5 clk = ~clk;

    always @(negedge clk)
    begin
        if (hold_on)
        begin
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // long receiver hold-off, counted in cycles
    initial
    begin : hold_counter
        forever
        begin
            @(hold_start);
            hold_on = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clk);
            hold_on = 1'b0;
        end
    end

    function automatic int unsigned clip(int unsigned v, int unsigned lo, int unsigned hi);
        if (v < lo)
        begin
            return lo;
        end
        if (v > hi)
        begin
            return hi;
        end
        return v;
    endfunction

    function automatic int unsigned origin_step(int unsigned span_step);
        return (reg_overlap >= span_step) ? 1 : span_step - reg_overlap;
    endfunction

    function automatic int unsigned tile_len(int unsigned total, int unsigned org,
                                             int unsigned span_step, output bit ends);
        int unsigned remain;
        remain = total - org;
        ends = (remain <= span_step + reg_grace);
        return ends ? remain : span_step;
    endfunction

    function automatic int unsigned aligned_dim(logic [DIM_W-1:0] v);
        int unsigned a;
        int unsigned d;
        a = clip(reg_align, 1, MAX_ALIGN);
        d = clip(v, 1, MAX_DIM);
        return ((d + a - 1) / a) * a;
    endfunction

    function automatic int tiles_across(int unsigned total, int unsigned span_step);
        int unsigned org;
        int          n;
        bit          ends;
        org = 0;
        n = 0;
        ends = 1'b0;
        while (!ends && n < 1000)
        begin
            void'(tile_len(total, org, span_step, ends));
            n++;
            org += origin_step(span_step);
        end
        return n;
    endfunction

    // expected results of one request; advances the walk
    function automatic void predict_tiles(logic [DIM_W-1:0] h, logic [DIM_W-1:0] w,
                                          logic alpha);
        int unsigned step_h;
        int unsigned step_w;
        int unsigned rows_len;
        int unsigned cols_len;
        bit          rows_end;
        bit          cols_end;
        bit          first;
        tile_t       t;
        step_h = clip(reg_tile_h, 1, MAX_TILE);
        step_w = clip(reg_tile_w, 1, MAX_TILE);
        if (!image_open)
        begin
            span_rows = aligned_dim(h);
            span_cols = aligned_dim(w);
            walk_row = 0;
            walk_col = 0;
            image_open = 1'b1;
        end
        rows_len = tile_len(span_rows, walk_row, step_h, rows_end);
        cols_len = tile_len(span_cols, walk_col, step_w, cols_end);
        t.y = DIM_W'(walk_row);
        t.x = DIM_W'(walk_col);
        t.rows = TILE_W'(rows_len);
        t.cols = TILE_W'(cols_len);
        t.top = (walk_row == 0);
        t.bottom = rows_end;
        t.left = (walk_col == 0);
        t.right = cols_end;
        first = t.top && t.left;
        if (alpha)
        begin
            t.alpha = 1'b1;
            t.img_begin = first;
            t.img_end = 1'b0;
            t.is_last = 1'b0;
            tiles_due.push_back(t);
            first = 1'b0;
        end
        t.alpha = 1'b0;
        t.img_begin = first;
        t.img_end = rows_end && cols_end;
        t.is_last = 1'b1;
        tiles_due.push_back(t);
        if (cols_end)
        begin
            walk_col = 0;
            if (rows_end)
            begin
                walk_row = 0;
                image_open = 1'b0;
            end
            else
            begin
                walk_row += origin_step(step_h);
            end
        end
        else
        begin
            walk_col += origin_step(step_w);
        end
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        $display("%0t ERROR %s: got %0d, expected %0d", $time, what, got, want);
        err_count++;
    endtask

    task automatic check_field(string what, int unsigned got, int unsigned want);
        if (got != want)
        begin
            report_mismatch(what, got, want);
        end
    endtask

    always @(posedge clk)
    begin : check_tiles
        tile_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (tiles_due.size() == 0)
            begin
                report_mismatch("tile with no request pending", 1, 0);
            end
            else
            begin
                want = tiles_due.pop_front();
                check_field("tile_y", tile_y, want.y);
                check_field("tile_x", tile_x, want.x);
                check_field("tile_rows", tile_rows, want.rows);
                check_field("tile_cols", tile_cols, want.cols);
                check_field("top_edge", top_edge, want.top);
                check_field("bottom_edge", bottom_edge, want.bottom);
                check_field("left_edge", left_edge, want.left);
                check_field("right_edge", right_edge, want.right);
                check_field("alpha_pass", alpha_pass, want.alpha);
                check_field("image_begin", image_begin, want.img_begin);
                check_field("image_end", image_end, want.img_end);
                check_field("last", last, want.is_last);
            end
        end
    end

    task automatic send_request(logic [DIM_W-1:0] h, logic [DIM_W-1:0] w, logic alpha);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        image_height <= h;
        image_width <= w;
        with_alpha <= alpha;
        do
            @(posedge clk);
        while (in_stall);
        predict_tiles(h, w, alpha);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (tiles_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        case (idx)
            CFG_TILE_WIDTH:     reg_tile_w = data;
            CFG_TILE_HEIGHT:    reg_tile_h = data;
            CFG_TILE_OVERLAP:   reg_overlap = OVL_W'(data);
            CFG_EXTEND_GRACE:   reg_grace = GRACE_W'(data);
            CFG_SIZE_ALIGNMENT: reg_align = ALIGN_W'(data);
            default: ;
        endcase
    endtask

    // spare index written last so any aliasing would show up
    task automatic apply_setting(logic [CFG_W-1:0] tw, logic [CFG_W-1:0] th,
                                 logic [CFG_W-1:0] ov, logic [CFG_W-1:0] gr,
                                 logic [CFG_W-1:0] al);
        write_reg(CFG_TILE_WIDTH, tw);
        write_reg(CFG_TILE_HEIGHT, th);
        write_reg(CFG_TILE_OVERLAP, ov);
        write_reg(CFG_EXTEND_GRACE, gr);
        write_reg(CFG_SIZE_ALIGNMENT, al);
        write_reg(IDX_W'($urandom_range(CFG_SPARE_FIRST, CFG_SPARE_LAST)),
                  CFG_W'($urandom_range(0, CFG_FIELD_MAX)));
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic walk_image(logic [DIM_W-1:0] h, logic [DIM_W-1:0] w, bit alpha_first);
        int k;
        k = 0;
        do
        begin
            send_request(h, w, alpha_first ^ k[0]);
            k++;
        end
        while (image_open);
    endtask

    function automatic logic [CFG_W-1:0] pick_tile_size();
        case ($urandom_range(0, 3))
            0: return CFG_W'($urandom_range(1, 64));
            1: return CFG_W'($urandom_range(65, 1024));
            2: return CFG_W'($urandom_range(1025, CFG_FIELD_MAX));
            default:
                case ($urandom_range(0, 3))
                    0: return CFG_W'(0);
                    1: return CFG_W'(1);
                    2: return CFG_W'(MAX_TILE);
                    default: return CFG_W'(CFG_FIELD_MAX);
                endcase
        endcase
    endfunction

    task automatic randomise_setting();
        logic [CFG_W-1:0] tw;
        logic [CFG_W-1:0] th;
        logic [CFG_W-1:0] ov;
        logic [CFG_W-1:0] gr;
        logic [CFG_W-1:0] al;
        int unsigned      sw;
        int unsigned      sh;
        int unsigned      adv;
        tw = pick_tile_size();
        th = pick_tile_size();
        case ($urandom_range(0, 3))
            0: ov = CFG_W'(0);
            1: ov = CFG_W'(1023);
            default: ov = CFG_W'($urandom_range(0, CFG_FIELD_MAX));
        endcase
        case ($urandom_range(0, 3))
            0: gr = CFG_W'(0);
            1: gr = CFG_W'(4095);
            2: gr = CFG_W'($urandom_range(0, 32));
            default: gr = CFG_W'($urandom_range(0, CFG_FIELD_MAX));
        endcase
        case ($urandom_range(0, 3))
            0: al = CFG_W'(0);
            1: al = CFG_W'(1);
            2: al = CFG_W'(MAX_ALIGN);
            default: al = CFG_W'($urandom_range(0, 511));
        endcase
        // keep alignment small against the advance so images stay a few tiles wide
        sw = clip(tw, 1, MAX_TILE);
        sh = clip(th, 1, MAX_TILE);
        adv = (ov[OVL_W-1:0] >= sw) ? 1 : sw - ov[OVL_W-1:0];
        if (sh < sw)
        begin
            adv = (ov[OVL_W-1:0] >= sh) ? 1 : sh - ov[OVL_W-1:0];
        end
        if (clip(al[ALIGN_W-1:0], 1, MAX_ALIGN) > 4 * adv)
        begin
            al = CFG_W'($urandom_range(0, clip(adv, 1, MAX_ALIGN)));
        end
        apply_setting(tw, th, ov, gr, al);
    endtask

    task automatic pick_image(output logic [DIM_W-1:0] h, output logic [DIM_W-1:0] w);
        int unsigned step_h;
        int unsigned step_w;
        int unsigned lim_h;
        int unsigned lim_w;
        int          tries;
        step_h = clip(reg_tile_h, 1, MAX_TILE);
        step_w = clip(reg_tile_w, 1, MAX_TILE);
        lim_h = clip(origin_step(step_h) * 4 + step_h + reg_grace, 0, DIM_FIELD_MAX);
        lim_w = clip(origin_step(step_w) * 4 + step_w + reg_grace, 0, DIM_FIELD_MAX);
        tries = 0;
        do
        begin
            h = DIM_W'($urandom_range(0, lim_h));
            w = DIM_W'($urandom_range(0, lim_w));
            tries++;
            if (tries > 8)
            begin
                lim_h = lim_h / 2;
                lim_w = lim_w / 2;
            end
        end
        while (tiles_across(aligned_dim(h), step_h) * tiles_across(aligned_dim(w), step_w)
               > MAX_TILES_PER_IMAGE);
    endtask

    task automatic test_reset_defaults();
        walk_image(300, 300, 1'b0);
    endtask

    // zero and oversized sizes, overlap above tile size, largest grace
    task automatic test_clamping();
        wait_idle();
        apply_setting(0, CFG_W'(CFG_FIELD_MAX), 1023, 4095, 0);
        walk_image(0, 0, 1'b1);
        walk_image(DIM_W'(DIM_FIELD_MAX), 3, 1'b0);
    endtask

    task automatic test_alignment();
        wait_idle();
        apply_setting(CFG_W'(MAX_TILE), CFG_W'(MAX_TILE), 0, 0, 511);
        walk_image(1, 257, 1'b1);
        walk_image(300, 1, 1'b0);
    endtask

    // size change mid-image must be ignored
    task automatic test_overlap_resize();
        wait_idle();
        apply_setting(4, 2, 4, 0, 1);
        send_request(3, 7, 1'b1);
        while (image_open)
        begin
            send_request(DIM_W'($urandom_range(0, DIM_FIELD_MAX)),
                         DIM_W'($urandom_range(0, DIM_FIELD_MAX)),
                         1'($urandom_range(0, 1)));
        end
    endtask

    task automatic test_backpressure();
        wait_idle();
        apply_setting(16, 16, 0, 0, 1);
        @(posedge clk);
        -> hold_start;
        walk_image(64, 64, 1'b1);
    endtask

    task automatic run_random(int send_pct, int recv_pct);
        int               sent;
        int               in_setting;
        logic [DIM_W-1:0] img_h;
        logic [DIM_W-1:0] img_w;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        sent = 0;
        img_h = '0;
        img_w = '0;
        while (sent < PHASE_ITEMS)
        begin
            wait_idle();
            randomise_setting();
            in_setting = 0;
            while (in_setting < SETTING_ITEMS || image_open)
            begin
                if (!image_open)
                begin
                    pick_image(img_h, img_w);
                end
                if (image_open && $urandom_range(0, 9) == 0)
                begin
                    send_request(DIM_W'($urandom_range(0, DIM_FIELD_MAX)),
                                 DIM_W'($urandom_range(0, DIM_FIELD_MAX)),
                                 1'($urandom_range(0, 1)));
                end
                else
                begin
                    send_request(img_h, img_w, 1'($urandom_range(0, 1)));
                end
                in_setting++;
            end
            sent += in_setting;
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_TILE_WIDTH;
        cfg_data = '0;
        in_valid = 1'b0;
        image_height = '0;
        image_width = '0;
        with_alpha = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_clamping();
        test_alignment();
        test_overlap_resize();
        test_backpressure();
        run_random(35, 57);
        run_random(57, 35);
        run_random(0, 0);
        wait_idle();

        if (err_count == 0)
        begin
            $display("tb_overlapped_tile_walker_core: done, clean");
        end
        else
        begin
            $display("tb_overlapped_tile_walker_core: done, errors");
        end
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("TIMEOUT waiting for requests or tiles");
        $display("tb_overlapped_tile_walker_core: done, errors");
        $finish;
    end

endmodule

### files.f
+incdir+sv
sv/otw_pkg.sv
sv/otw_rem.sv
sv/otw_dp.sv
sv/otw_ctrl.sv
sv/overlapped_tile_walker_core.sv
tb/tb_overlapped_tile_walker_core.sv
